@@ rtl/crdg_pkg.sv @@
// crdg_pkg: shared widths, register codes, reset values and word types
// for the camera ray direction generator
// depends on nothing
package crdg_pkg;

   localparam int COORD_W = 10;   // pixel coordinate
   localparam int OUT_W = 16;     // signed q2.14 direction component
   localparam int CFG_W = 63;     // widest register
   localparam int FLD_W = 21;     // signed q10.10 position field
   localparam int TAN_W = 24;     // unsigned q8.16 tan of half fov
   localparam int CSR_IDX_W = 3;
   localparam int AB_W = 14;      // signed pixel offset from image center
   localparam int BAS_W = 38;     // widest basis vector before normalizing
   localparam int RT_W = 41;      // basis component times tan
   localparam int FH_W = 47;      // forward times height times 2^16
   localparam int DIR_W = 57;     // unnormalized ray direction component
   localparam int FQ_DEPTH = 4;   // queue between front and back

   localparam int DEF_IMAGE_WIDTH = 1024;
   localparam int DEF_IMAGE_HEIGHT = 768;

   localparam logic [CFG_W-1:0] EYE_RST = 63'd0;
   localparam logic [CFG_W-1:0] TARGET_RST = 63'd4503599627370496;
   localparam logic [CFG_W-1:0] UP_RST = 63'd2147483648;
   localparam logic [TAN_W-1:0] TAN_RST = 24'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EYE    = 3'd0,
      CSR_TARGET = 3'd1,
      CSR_UP     = 3'd2,
      CSR_TAN    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [AB_W-1:0] a;
      logic signed [AB_W-1:0] b;
   } item_type;

   typedef struct packed {
      logic [2:0][RT_W-1:0] rt;
      logic [2:0][RT_W-1:0] ut;
      logic [2:0][FH_W-1:0] fh;
      logic                 degen;
   } basis_type;

endpackage

@@ rtl/crdg_norm.sv @@
// crdg_norm: pipelined normalizer of a signed 3-vector into q2.14
// leading-one shift, sum of squares, bit-serial square root, restoring divide
// depends on crdg_pkg
module crdg_norm import crdg_pkg::*; #(
   parameter int VEC_W = DIR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [2:0][VEC_W-1:0]       in_vec,
   output logic                        out_valid,
   output logic [2:0][OUT_W-1:0]       out_vec,
   output logic                        out_zero
);

   localparam int NCH = (VEC_W + 7) / 8;
   localparam int PAD_W = NCH * 8;
   localparam int SH_W = $clog2(VEC_W + 1);
   localparam int N_W = 31;
   localparam int WIDE_W = VEC_W + N_W;
   localparam int SQ_STEPS = 32;
   localparam int S_W = 64;
   localparam int REM_W = 35;
   localparam int ROOT_W = 32;
   localparam int DIV_STEPS = 15;
   localparam int DREM_W = 46;

   typedef struct packed {
      logic                 valid;
      logic [S_W-1:0]       s;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
      logic [2:0][N_W-1:0]  n;
      logic [2:0]           neg;
      logic                 zero;
   } sqrt_stage_type;

   typedef struct packed {
      logic                     valid;
      logic [ROOT_W-1:0]        l;
      logic [2:0][DREM_W-1:0]   rem;
      logic [2:0][DIV_STEPS-1:0] q;
      logic [2:0]               neg;
      logic                     zero;
   } div_stage_type;

   // front stages
   logic                      v0_valid_ff;
   logic [2:0][VEC_W-1:0]     v0_ff;
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                      s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic [2:0][VEC_W-1:0]     mag1_ff, mag2_ff, mag3_ff, mag4_ff;
   logic [2:0][VEC_W-1:0]     mag1_in;
   logic [2:0]                neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [2:0]                neg1_in;
   logic [VEC_W-1:0]          max2_ff, max2_in;
   logic [NCH-1:0]            nz3_ff, nz3_in;
   logic [NCH-1:0][2:0]       pos3_ff, pos3_in;
   logic [PAD_W-1:0]          max_pad;
   logic [SH_W-1:0]           sh4_ff, sh4_in;
   logic                      zero4_ff, zero5_ff, zero6_ff, zero7_ff;
   logic [2:0][WIDE_W-1:0]    wide5_ff, wide5_in;
   logic [2:0]                fine5_ff;
   logic [2:0][N_W-1:0]       n6_ff, n6_in, n7_ff;
   logic [2:0][61:0]          sq7_ff, sq7_in;
   logic [2:0][WIDE_W-1:0]    fine_tmp;
   logic [2:0][OUT_W-1:0]     out_in;

   sqrt_stage_type sq_ff [0:SQ_STEPS];
   sqrt_stage_type sq0_in;
   div_stage_type  dv_ff [0:DIV_STEPS];
   div_stage_type  dv0_in;

   logic                      out_valid_ff;
   logic [2:0][OUT_W-1:0]     out_ff;
   logic                      out_zero_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg1_in[k] = v0_ff[k][VEC_W-1];
         mag1_in[k] = neg1_in[k] ? (~v0_ff[k] + 1'b1) : v0_ff[k];
      end
   end

   always_comb begin
      max2_in = mag1_ff[0];
      if (mag1_ff[1] > max2_in) begin
         max2_in = mag1_ff[1];
      end
      if (mag1_ff[2] > max2_in) begin
         max2_in = mag1_ff[2];
      end
   end

   // leading one: per-byte flags and positions, then highest nonzero byte
   always_comb begin
      max_pad = PAD_W'(max2_ff);
      for (int c = 0; c < NCH; c++) begin
         nz3_in[c] = |max_pad[c*8 +: 8];
         pos3_in[c] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (max_pad[c*8 + b]) begin
               pos3_in[c] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      sh4_in = '0;
      for (int c = 0; c < NCH; c++) begin
         if (nz3_ff[c]) begin
            sh4_in = SH_W'(c * 8) + SH_W'(pos3_ff[c]) + SH_W'(1);
         end
      end
   end

   // leading one lands on bit 30 after the right shift by position plus one
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wide5_in[k] = {mag4_ff[k], {N_W{1'b0}}} >> {sh4_ff[SH_W-1:3], 3'b000};
         fine_tmp[k] = wide5_ff[k] >> fine5_ff;
         n6_in[k] = fine_tmp[k][N_W-1:0];
         sq7_in[k] = 62'(n6_ff[k]) * 62'(n6_ff[k]);
      end
   end

   always_comb begin
      sq0_in.valid = s7_valid_ff;
      sq0_in.s = 64'(sq7_ff[0]) + 64'(sq7_ff[1]) + 64'(sq7_ff[2]);
      sq0_in.rem = '0;
      sq0_in.root = '0;
      sq0_in.n = n7_ff;
      sq0_in.neg = neg7_ff;
      sq0_in.zero = zero7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         sq_ff[0] <= '0;
      end else if (en) begin
         v0_valid_ff <= in_valid;
         s1_valid_ff <= v0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         sq_ff[0] <= sq0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v0_ff <= in_vec;
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         max2_ff <= max2_in;
         mag3_ff <= mag2_ff;
         neg3_ff <= neg2_ff;
         nz3_ff <= nz3_in;
         pos3_ff <= pos3_in;
         mag4_ff <= mag3_ff;
         neg4_ff <= neg3_ff;
         sh4_ff <= sh4_in;
         zero4_ff <= ~(|nz3_ff);
         wide5_ff <= wide5_in;
         fine5_ff <= sh4_ff[2:0];
         neg5_ff <= neg4_ff;
         zero5_ff <= zero4_ff;
         n6_ff <= n6_in;
         neg6_ff <= neg5_ff;
         zero6_ff <= zero5_ff;
         sq7_ff <= sq7_in;
         n7_ff <= n6_ff;
         neg7_ff <= neg6_ff;
         zero7_ff <= zero6_ff;
      end
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      sqrt_stage_type   st_in;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;

      always_comb begin
         st_in = sq_ff[k];
         rem_sh = {sq_ff[k].rem[REM_W-3:0], sq_ff[k].s[S_W-1-2*k -: 2]};
         trial = REM_W'({sq_ff[k].root, 2'b01});
         if (rem_sh >= trial) begin
            st_in.rem = rem_sh - trial;
            st_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b1};
         end else begin
            st_in.rem = rem_sh;
            st_in.root = {sq_ff[k].root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k+1] <= '0;
         end else if (en) begin
            sq_ff[k+1] <= st_in;
         end
      end
   end

   // rounded dividend: magnitude times 2^14 plus half the length
   always_comb begin
      dv0_in.valid = sq_ff[SQ_STEPS].valid;
      dv0_in.l = sq_ff[SQ_STEPS].root;
      dv0_in.q = '0;
      dv0_in.neg = sq_ff[SQ_STEPS].neg;
      dv0_in.zero = sq_ff[SQ_STEPS].zero;
      for (int k = 0; k < 3; k++) begin
         dv0_in.rem[k] = DREM_W'({sq_ff[SQ_STEPS].n[k], 14'd0}) +
                         DREM_W'(sq_ff[SQ_STEPS].root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= '0;
      end else if (en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // restoring divide, one quotient bit per stage, msb first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int QB = DIV_STEPS - 1 - j;
      div_stage_type     st_in;
      logic [DREM_W-1:0] dsh;

      always_comb begin
         st_in = dv_ff[j];
         dsh = DREM_W'(dv_ff[j].l) << QB;
         for (int k = 0; k < 3; k++) begin
            if (dv_ff[j].rem[k] >= dsh) begin
               st_in.rem[k] = dv_ff[j].rem[k] - dsh;
               st_in.q[k][QB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= '0;
         end else if (en) begin
            dv_ff[j+1] <= st_in;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_ff[DIV_STEPS].zero) begin
            out_in[k] = '0;
         end else if (dv_ff[DIV_STEPS].neg[k]) begin
            out_in[k] = OUT_W'(0) - OUT_W'(dv_ff[DIV_STEPS].q[k]);
         end else begin
            out_in[k] = OUT_W'(dv_ff[DIV_STEPS].q[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_ff[DIV_STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
         out_zero_ff <= dv_ff[DIV_STEPS].zero;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec = out_ff;
   assign out_zero = out_zero_ff;

endmodule

@@ rtl/crdg_basis.sv @@
// crdg_basis: camera registers and the sequencer that rebuilds the
// look-at basis through one normalizer after reset and each register write
// depends on crdg_pkg, crdg_norm
module crdg_basis import crdg_pkg::*; #(
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output logic                  busy,
   output basis_type             basis
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FWD  = 5'b00010,
      ST_RGT  = 5'b00100,
      ST_UP   = 5'b01000,
      ST_PROD = 5'b10000
   } state_type;

   localparam logic signed [FH_W-1:0] HEIGHT_X = FH_W'(IMAGE_HEIGHT);

   logic [CFG_W-1:0] eye_ff, eye_in, tgt_ff, tgt_in, uph_ff, uph_in;
   logic [TAN_W-1:0] tan_ff, tan_in;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;
   logic      inflight_ff, inflight_in;
   logic      degen_ff, degen_in;

   logic [2:0][OUT_W-1:0] fwd_ff, fwd_in, rgt_ff, rgt_in, upv_ff, upv_in;
   logic [2:0][RT_W-1:0]  rt_ff, rt_in, ut_ff, ut_in;
   logic [2:0][FH_W-1:0]  fh_ff, fh_in;

   logic                  n_valid_in;
   logic [2:0][BAS_W-1:0] n_vec_in;
   logic                  n_out_valid;
   logic [2:0][OUT_W-1:0] n_out_vec;
   logic                  n_out_zero;

   logic [2:0][BAS_W-1:0] diff_vec, xr_vec, xu_vec;
   logic signed [FLD_W-1:0] hv [3];
   logic signed [OUT_W-1:0] fv [3];
   logic signed [OUT_W-1:0] rv [3];
   logic signed [OUT_W-1:0] fq [3];
   logic signed [OUT_W-1:0] rq [3];
   logic signed [OUT_W-1:0] uq [3];
   logic signed [TAN_W:0]   tan_s;

   always_comb begin
      eye_in = eye_ff;
      tgt_in = tgt_ff;
      uph_in = uph_ff;
      tan_in = tan_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EYE: begin
               eye_in = csr_wdata;
            end
            CSR_TARGET: begin
               tgt_in = csr_wdata;
            end
            CSR_UP: begin
               uph_in = csr_wdata;
            end
            CSR_TAN: begin
               tan_in = csr_wdata[TAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff <= EYE_RST;
         tgt_ff <= TARGET_RST;
         uph_ff <= UP_RST;
         tan_ff <= TAN_RST;
      end else begin
         eye_ff <= eye_in;
         tgt_ff <= tgt_in;
         uph_ff <= uph_in;
         tan_ff <= tan_in;
      end
   end

   crdg_norm #(
      .VEC_W (BAS_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (1'b1),
      .in_valid  (n_valid_in),
      .in_vec    (n_vec_in),
      .out_valid (n_out_valid),
      .out_vec   (n_out_vec),
      .out_zero  (n_out_zero)
   );

   // candidate vectors: target minus eye, hint x forward, forward x right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hv[k] = $signed(uph_ff[k*FLD_W +: FLD_W]);
         fv[k] = $signed(n_out_vec[k]);
         rv[k] = $signed(n_out_vec[k]);
         fq[k] = $signed(fwd_ff[k]);
         diff_vec[k] = BAS_W'($signed(tgt_ff[k*FLD_W +: FLD_W])) -
                       BAS_W'($signed(eye_ff[k*FLD_W +: FLD_W]));
      end
      xr_vec[0] = BAS_W'(hv[1]) * BAS_W'(fv[2]) - BAS_W'(hv[2]) * BAS_W'(fv[1]);
      xr_vec[1] = BAS_W'(hv[2]) * BAS_W'(fv[0]) - BAS_W'(hv[0]) * BAS_W'(fv[2]);
      xr_vec[2] = BAS_W'(hv[0]) * BAS_W'(fv[1]) - BAS_W'(hv[1]) * BAS_W'(fv[0]);
      xu_vec[0] = BAS_W'(fq[1]) * BAS_W'(rv[2]) - BAS_W'(fq[2]) * BAS_W'(rv[1]);
      xu_vec[1] = BAS_W'(fq[2]) * BAS_W'(rv[0]) - BAS_W'(fq[0]) * BAS_W'(rv[2]);
      xu_vec[2] = BAS_W'(fq[0]) * BAS_W'(rv[1]) - BAS_W'(fq[1]) * BAS_W'(rv[0]);
   end

   // a write during a rebuild drops the in-flight result and starts over
   always_comb begin
      state_in = state_ff;
      pending_in = pending_ff;
      inflight_in = inflight_ff;
      degen_in = degen_ff;
      fwd_in = fwd_ff;
      rgt_in = rgt_ff;
      upv_in = upv_ff;
      n_valid_in = 1'b0;
      n_vec_in = diff_vec;
      if (n_out_valid) begin
         inflight_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pending_ff && !inflight_ff) begin
               n_valid_in = 1'b1;
               n_vec_in = diff_vec;
               pending_in = 1'b0;
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            if (n_out_valid) begin
               if (pending_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  fwd_in = n_out_vec;
                  degen_in = n_out_zero;
                  n_valid_in = 1'b1;
                  n_vec_in = xr_vec;
                  state_in = ST_RGT;
               end
            end
         end
         ST_RGT: begin
            if (n_out_valid) begin
               if (pending_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rgt_in = n_out_vec;
                  degen_in = degen_ff | n_out_zero;
                  n_valid_in = 1'b1;
                  n_vec_in = xu_vec;
                  state_in = ST_UP;
               end
            end
         end
         ST_UP: begin
            if (n_out_valid) begin
               if (pending_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  upv_in = n_out_vec;
                  degen_in = degen_ff | n_out_zero;
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (n_valid_in) begin
         inflight_in = 1'b1;
      end
      if (csr_we) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pending_ff <= 1'b1;
         inflight_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pending_ff <= pending_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      degen_ff <= degen_in;
      fwd_ff <= fwd_in;
      rgt_ff <= rgt_in;
      upv_ff <= upv_in;
   end

   // per-ray scale factors: right and up times tan, forward times height
   always_comb begin
      tan_s = $signed({1'b0, tan_ff});
      for (int k = 0; k < 3; k++) begin
         rq[k] = $signed(rgt_ff[k]);
         uq[k] = $signed(upv_ff[k]);
         rt_in[k] = RT_W'(rq[k]) * RT_W'(tan_s);
         ut_in[k] = RT_W'(uq[k]) * RT_W'(tan_s);
         fh_in[k] = (FH_W'(fq[k]) * HEIGHT_X) <<< 16;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_PROD) begin
         rt_ff <= rt_in;
         ut_ff <= ut_in;
         fh_ff <= fh_in;
      end
   end

   assign busy = (state_ff != ST_IDLE) || pending_ff;
   assign basis.rt = rt_ff;
   assign basis.ut = ut_ff;
   assign basis.fh = fh_ff;
   assign basis.degen = degen_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      n_valid_in |-> (!inflight_ff || n_out_valid))
      else $error("basis issued a vector while one is in flight");
   a_result_expected: assert property (@(posedge clock) disable iff (reset)
      n_out_valid |-> inflight_ff)
      else $error("basis normalizer result with nothing in flight");
   a_ready_after_prod: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(state_ff == ST_PROD))
      else $error("basis went ready without computing scale factors");
`endif

endmodule

@@ rtl/crdg_front.sv @@
// crdg_front: takes pixel words, turns them into signed offsets from the
// image center and holds them in a short queue for the back end
// depends on crdg_pkg
module crdg_front import crdg_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic [COORD_W-1:0] req_pixel_x,
   input  logic [COORD_W-1:0] req_pixel_y,
   output logic               req_full,
   input  logic               basis_busy,
   input  logic               q_pop,
   output logic               q_valid,
   output item_type           q_item
);

   localparam int PTR_W = $clog2(FQ_DEPTH);
   localparam int CNT_W = $clog2(FQ_DEPTH + 1);

   item_type         fq_ff [FQ_DEPTH];
   item_type         item_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_full = (count_ff == CNT_W'(FQ_DEPTH)) || basis_busy;
   assign push = req_push && !req_full;

   // offsets W-2x-1 and H-2y-1, column zero toward +right
   always_comb begin
      item_in.a = AB_W'(IMAGE_WIDTH - 1) - AB_W'({req_pixel_x, 1'b0});
      item_in.b = AB_W'(IMAGE_HEIGHT - 1) - AB_W'({req_pixel_y, 1'b0});
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fq_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item = fq_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FQ_DEPTH))
      else $error("front queue overflow");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("front queue lost a word");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");
`endif

endmodule

@@ rtl/crdg_back.sv @@
// crdg_back: builds the unnormalized ray from the basis scale factors,
// normalizes it and holds the finished word in the output register
// depends on crdg_pkg, crdg_norm
module crdg_back import crdg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  item_type                 q_item,
   output logic                     q_pop,
   input  basis_type                basis,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [OUT_W-1:0]  rsp_dir_x,
   output logic signed [OUT_W-1:0]  rsp_dir_y,
   output logic signed [OUT_W-1:0]  rsp_dir_z,
   output logic                     rsp_degenerate
);

   logic                  en;
   logic                  d1_valid_ff;
   logic [2:0][DIR_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [2:0][DIR_W-1:0] d_vec;

   logic                  n_out_valid;
   logic [2:0][OUT_W-1:0] n_out_vec;
   logic                  n_out_zero;

   logic                  out_valid_ff;
   logic [2:0][OUT_W-1:0] dir_ff, dir_in;
   logic                  degen_ff, degen_in;

   // whole pipeline advances while the output register can take a word
   assign en = !out_valid_ff || rsp_pop;
   assign q_pop = en && q_valid;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = DIR_W'($signed(basis.rt[k])) * DIR_W'(q_item.a);
         pb_in[k] = DIR_W'($signed(basis.ut[k])) * DIR_W'(q_item.b);
         d_vec[k] = pa_ff[k] + pb_ff[k] + DIR_W'($signed(basis.fh[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else if (en) begin
         d1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   crdg_norm #(
      .VEC_W (DIR_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid_ff),
      .in_vec    (d_vec),
      .out_valid (n_out_valid),
      .out_vec   (n_out_vec),
      .out_zero  (n_out_zero)
   );

   always_comb begin
      degen_in = n_out_zero || basis.degen;
      dir_in = degen_in ? '0 : n_out_vec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= n_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff <= dir_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_dir_x = $signed(dir_ff[0]);
   assign rsp_dir_y = $signed(dir_ff[1]);
   assign rsp_dir_z = $signed(dir_ff[2]);
   assign rsp_degenerate = degen_ff;

endmodule

@@ rtl/camera_ray_direction_generator_unit.sv @@
// camera_ray_direction_generator_unit: top level of the primary ray generator
// depends on crdg_pkg, crdg_basis, crdg_front, crdg_back
//
//   channel  handshake        word
//   req      push / full      pixel_x, pixel_y
//   rsp      pop / empty      dir_x, dir_y, dir_z, degenerate (q2.14)
//   csr      we, index        wdata: eye, target, up hint, tan half fov
//
// one ray per clock while full is low and no rsp stall holds the pipeline; the
// square root (32 stages) and divide (15 stages) of the normalizer make up most of its depth
// after reset and after any csr write the basis is rebuilt through its own
// normalizer, three passes, with full held high
// an output register and the four-word front queue let each side stall alone;
// a rsp stall freezes the back pipeline
module camera_ray_direction_generator_unit import crdg_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [COORD_W-1:0]       req_pixel_x,
   input  logic [COORD_W-1:0]       req_pixel_y,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [OUT_W-1:0]  rsp_dir_x,
   output logic signed [OUT_W-1:0]  rsp_dir_y,
   output logic signed [OUT_W-1:0]  rsp_dir_z,
   output logic                     rsp_degenerate,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   logic      basis_busy;
   basis_type basis;
   logic      q_pop;
   logic      q_valid;
   item_type  q_item;

   crdg_basis #(
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_basis (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (basis_busy),
      .basis     (basis)
   );

   crdg_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .req_full    (req_full),
      .basis_busy  (basis_busy),
      .q_pop       (q_pop),
      .q_valid     (q_valid),
      .q_item      (q_item)
   );

   crdg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .basis          (basis),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_dir_x      (rsp_dir_x),
      .rsp_dir_y      (rsp_dir_y),
      .rsp_dir_z      (rsp_dir_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for camera_ray_direction_generator_unit
// depends on crdg_pkg and the unit; pixel words checked against an internal ray predictor
`timescale 1ns / 1ps

module tb_top;
   import crdg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd6;
   localparam int SETTLE_CYCLES = 80;
   localparam int ONE_Q10 = 1024;

   typedef struct packed {
      logic signed [OUT_W-1:0] dx;
      logic signed [OUT_W-1:0] dy;
      logic signed [OUT_W-1:0] dz;
      logic                    degen;
   } ray_type;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     data;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic                 fixed;
      ray_type              want;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [COORD_W-1:0]      req_pixel_x = '0;
   logic [COORD_W-1:0]      req_pixel_y = '0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic signed [OUT_W-1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic                    rsp_degenerate;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   camera_ray_direction_generator_unit i_dut (.*);

   // camera registers as the predictor sees them
   logic [CFG_W-1:0] cam_eye, cam_target, cam_up;
   logic [TAN_W-1:0] cam_tan;

   ray_type rays_pending[$];
   int      mismatches = 0;
   int      words_checked = 0;
   int      pixels_sent = 0;
   int      writes_done = 0;
   int      send_idle_pct = 0;
   int      pop_stall_pct = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic report(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   function automatic longint unsigned root_floor(input longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // scale to q2.14 unit length; ok is 0 for a zero vector
   function automatic void unit_q14(input longint v[3], output longint o[3], output bit ok);
      longint unsigned mag[3], m, s, l, q;
      m = 0;
      s = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = v[k] < 0 ? -v[k] : v[k];
         if (mag[k] > m) m = mag[k];
      end
      ok = (m != 0);
      for (int k = 0; k < 3; k++) o[k] = 0;
      if (ok) begin
         while (m >= (64'd1 << 31)) begin
            m >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
         end
         while (m < (64'd1 << 30)) begin
            m <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
         end
         for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
         l = root_floor(s);
         for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 14) + (l >> 1)) / l;
            o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
         end
      end
   endfunction

   function automatic void cross_prod(input longint p[3], input longint r[3],
                                      output longint o[3]);
      o[0] = p[1] * r[2] - p[2] * r[1];
      o[1] = p[2] * r[0] - p[0] * r[2];
      o[2] = p[0] * r[1] - p[1] * r[0];
   endfunction

   function automatic longint coord(input logic [CFG_W-1:0] w, input int k);
      return longint'($signed(w[FLD_W*k +: FLD_W]));
   endfunction

   function automatic ray_type predict_ray(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
      longint diff[3], hint[3], fwd[3], tmp[3], rgt[3], upv[3], d[3], dir[3];
      longint a, b, t;
      bit ok1, ok2, ok3, ok4;
      ray_type r;
      for (int k = 0; k < 3; k++) begin
         diff[k] = coord(cam_target, k) - coord(cam_eye, k);
         hint[k] = coord(cam_up, k);
      end
      unit_q14(diff, fwd, ok1);
      cross_prod(hint, fwd, tmp);
      unit_q14(tmp, rgt, ok2);
      cross_prod(fwd, rgt, tmp);
      unit_q14(tmp, upv, ok3);
      a = DEF_IMAGE_WIDTH - 2 * longint'(x) - 1;
      b = DEF_IMAGE_HEIGHT - 2 * longint'(y) - 1;
      t = longint'(cam_tan);
      for (int k = 0; k < 3; k++)
         d[k] = rgt[k] * a * t + upv[k] * b * t + fwd[k] * DEF_IMAGE_HEIGHT * 65536;
      unit_q14(d, dir, ok4);
      r.degen = !(ok1 && ok2 && ok3 && ok4);
      r.dx = r.degen ? '0 : OUT_W'(dir[0]);
      r.dy = r.degen ? '0 : OUT_W'(dir[1]);
      r.dz = r.degen ? '0 : OUT_W'(dir[2]);
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] pos(input int x, input int y, input int z);
      logic [FLD_W-1:0] fx, fy, fz;
      fx = FLD_W'(x);
      fy = FLD_W'(y);
      fz = FLD_W'(z);
      return {fz, fy, fx};
   endfunction

   function automatic int rand_field();
      case ($urandom_range(0, 5))
         0: return -(1 << 20);
         1: return (1 << 20) - 1;
         2: return int'($urandom_range(0, 2 * 4096)) - 4096;
         default: return int'($urandom_range(0, (1 << 21) - 1)) - (1 << 20);
      endcase
   endfunction

   // send one pixel word; called at a rising edge, returns at the edge of acceptance
   task automatic put_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input bit fixed, input ray_type want);
      req_push <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      forever begin
         @(negedge clock);
         if (!req_full) break;
         @(posedge clock);
      end
      rays_pending.push_back(fixed ? want : predict_ray(x, y));
      pixels_sent++;
      @(posedge clock);
   endtask

   // register write only with the pipeline empty and settled
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      req_push <= 1'b0;
      while (rays_pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_EYE:    cam_eye = data;
         CSR_TARGET: cam_target = data;
         CSR_UP:     cam_up = data;
         CSR_TAN:    cam_tan = data[TAN_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // result side: pop decided at the rising edge, word checked at the falling edge
   initial begin
      ray_type want;
      @(posedge clock);
      forever begin
         rsp_pop <= (reset == 1'b0) && ($urandom_range(0, 99) >= pop_stall_pct);
         @(negedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (rays_pending.size() == 0) begin
               report("unexpected word", rsp_dir_x, 0);
            end else begin
               want = rays_pending.pop_front();
               words_checked++;
               if (rsp_dir_x !== want.dx) report("dir_x", rsp_dir_x, want.dx);
               if (rsp_dir_y !== want.dy) report("dir_y", rsp_dir_y, want.dy);
               if (rsp_dir_z !== want.dz) report("dir_z", rsp_dir_z, want.dz);
               if (rsp_degenerate !== want.degen)
                  report("degenerate", rsp_degenerate, want.degen);
            end
         end
         @(posedge clock);
      end
   end

   initial begin
      row_type plan[$];
      ray_type none, degen_ray, straight;
      int wait_cycles;
      none = '0;
      degen_ray = '{dx: 0, dy: 0, dz: 0, degen: 1'b1};
      straight = '{dx: 0, dy: 0, dz: 16'sd16384, degen: 1'b0};
      cam_eye = EYE_RST;
      cam_target = TARGET_RST;
      cam_up = UP_RST;
      cam_tan = TAN_RST;

      // reset camera first, then corner pixels and the center of the image
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd1023, 10'd1023, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd512, 10'd384, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd1023, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd0, 10'd767, 1'b0, none});
      // eye on the target: zero forward
      plan.push_back('{ROW_WRITE, CSR_EYE, TARGET_RST, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd5, 10'd5, 1'b1, degen_ray});
      plan.push_back('{ROW_WRITE, CSR_EYE, EYE_RST, 10'd0, 10'd0, 1'b0, none});
      // up hint along forward: zero right
      plan.push_back('{ROW_WRITE, CSR_UP, pos(0, 0, ONE_Q10), 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd100, 10'd200, 1'b1, degen_ray});
      plan.push_back('{ROW_WRITE, CSR_UP, UP_RST, 10'd0, 10'd0, 1'b0, none});
      // zero field of view: every ray is forward
      plan.push_back('{ROW_WRITE, CSR_TAN, '0, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd1023, 10'd1023, 1'b1, straight});
      plan.push_back('{ROW_WRITE, CSR_TAN, 63'hFFFFFF, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd1023, 10'd1023, 1'b0, none});
      // unmapped index changes nothing
      plan.push_back('{ROW_WRITE, CSR_UNMAPPED, '1, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd700, 10'd10, 1'b0, none});
      // extreme positions, excess bits of the tan word dropped
      plan.push_back('{ROW_WRITE, CSR_EYE, pos(-(1 << 20), -(1 << 20), -(1 << 20)),
                       10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_WRITE, CSR_TARGET, pos((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1),
                       10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_WRITE, CSR_TAN, 63'h7FFF_FFFF_FF01_0000, 10'd0, 10'd0, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd341, 10'd682, 1'b0, none});
      plan.push_back('{ROW_PIXEL, CSR_EYE, '0, 10'd682, 10'd341, 1'b0, none});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].data);
         else put_pixel(plan[i].x, plan[i].y, plan[i].fixed, plan[i].want);
      end

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 61; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 61; end
            default: begin send_idle_pct = 7; pop_stall_pct = 7; end
         endcase
         for (int n = 0; n < 384; n++) begin
            if (n % 96 == 0) begin
               // new camera for each run of 96 random pixels
               write_reg(CSR_EYE, pos(rand_field(), rand_field(), rand_field()));
               if ($urandom_range(0, 2) == 0)
                  write_reg(CSR_TARGET, pos(rand_field(), rand_field(), rand_field()));
               else
                  write_reg(CSR_TARGET, cam_eye + pos(0, 0, 0) +
                            pos(0, 0, 0) ^ pos(0, 0, 0) ^ pos(rand_field(), 0, 0) ^
                            pos(0, 0, int'($urandom_range(1, 8192))));
               write_reg(CSR_UP, $urandom_range(0, 3) == 0 ?
                         pos(rand_field(), rand_field(), rand_field()) :
                         pos(int'($urandom_range(0, 512)) - 256, ONE_Q10, 0));
               write_reg(CSR_TAN, $urandom_range(0, 3) == 0 ? 63'($urandom_range(0, 24'hFFFFFF))
                                                            : 63'($urandom_range(0, 1 << 18)));
            end
            if ($urandom_range(0, 99) < send_idle_pct) begin
               req_push <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end
            put_pixel(COORD_W'($urandom), COORD_W'($urandom), 1'b0, none);
         end
      end

      req_push <= 1'b0;
      wait_cycles = 0;
      while (rays_pending.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rays_pending.size() != 0) report("words never returned", rays_pending.size(), 0);
      $display("covered %0d pixels, %0d register writes, %0d words checked",
               pixels_sent, writes_done, words_checked);
      $display("phases: free flow, sender gaps, receiver stalls, both idling");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/crdg_pkg.sv
rtl/crdg_norm.sv
rtl/crdg_basis.sv
rtl/crdg_front.sv
rtl/crdg_back.sv
rtl/camera_ray_direction_generator_unit.sv
tb/tb_top.sv
